// ===== rtl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// shared types and constants for the set-associative lru tag store
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam int ADDR_W  = 64;
   localparam int CNT_W   = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int SETB_W  = 3;
   localparam int BLKB_W  = 6;
   localparam int WAYS_W  = 4;
   localparam int SHIFT_W = 7;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SET_BITS    = 2'd0,
      REG_BLOCK_BITS  = 2'd1,
      REG_WAYS_IN_USE = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

// ===== rtl/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/set_assoc_lru_cache_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// tag store of a set-associative cache with lru replacement and hit/miss stats
// ----------------------------------------------------------------------------
// usage
//   request channel: drive req_address and raise start; the request is taken
//   at a rising edge where start is high and busy is low
//   response: rsp_valid pulses for exactly one cycle with hit, evicted and the
//   three saturating totals; the receiver cannot stall, so nothing waits
//   csr channel: csr_valid/csr_ready with csr_index and csr_data; the user
//   must write only while no request is in flight (the block does not
//   enforce this); csr_ready is always high
//   timing: the set row is read from ram at the accept edge, updated in the
//   lookup state and written back as the response is registered; busy is
//   high during this update, as the single-port-per-direction ram needs a
//   read-modify-write, so the next read always sees the written row
//   reset: synchronous; afterwards a clearing pass writes all 2**MAX_SET_BITS
//   set rows (64 by default) to all-invalid, one row a cycle, with busy high;
//   csr writes are taken during the pass
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [ADDR_W-1:0]     req_address,
   // response channel
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic                  rsp_evicted,
   output logic [CNT_W-1:0]      rsp_hit_total,
   output logic [CNT_W-1:0]      rsp_miss_total,
   output logic [CNT_W-1:0]      rsp_eviction_total,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SET_COUNT = 1 << MAX_SET_BITS;
   localparam int IDX_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int ENTRY_W  = 1 + RANK_W + ADDR_W;
   localparam int ROW_W    = MAX_WAYS * ENTRY_W;
   localparam int SEFF_W   = 4;

   // configuration registers
   logic [SETB_W-1:0] set_bits_ff;
   logic [BLKB_W-1:0] block_bits_ff;
   logic [WAYS_W-1:0] ways_ff;

   // control
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;

   // request held across the update cycle
   logic [IDX_W-1:0]  set_ff;
   logic [ADDR_W-1:0] tag_ff;

   // stats and response
   logic [CNT_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]  miss_cnt_ff, miss_cnt_in;
   logic [CNT_W-1:0]  evict_cnt_ff, evict_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff;
   logic              rsp_evicted_ff;

   // ram ports
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [ROW_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [ROW_W-1:0]  ram_rd_data;

   // address split
   logic [SEFF_W-1:0]  s_eff;
   logic [SHIFT_W-1:0] tag_shift;
   logic [ADDR_W-1:0]  addr_shifted;
   logic [IDX_W-1:0]   idx_mask;
   logic [IDX_W-1:0]   set_idx;
   logic [ADDR_W-1:0]  tag_val;
   logic               accept;

   // row update
   logic [MAX_WAYS-1:0]             in_use;
   logic [MAX_WAYS-1:0]             way_valid;
   logic [MAX_WAYS-1:0][RANK_W-1:0] way_rank;
   logic [MAX_WAYS-1:0][ADDR_W-1:0] way_tag;
   logic [MAX_WAYS-1:0]             match;
   logic [MAX_WAYS-1:0]             free;
   logic                            hit;
   logic                            has_free;
   logic [RANK_W-1:0]               hit_way;
   logic [RANK_W-1:0]               free_way;
   logic [RANK_W-1:0]               victim;
   logic [RANK_W-1:0]               tgt_way;
   logic [RANK_W:0]                 old_rank;
   logic [ROW_W-1:0]                new_row;

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SET_COUNT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && (state_ff == ST_IDLE);

   // set index and tag from the address
   always_comb begin
      if (int'(set_bits_ff) > MAX_SET_BITS) begin
         s_eff = SEFF_W'(MAX_SET_BITS);
      end else begin
         s_eff = SEFF_W'(set_bits_ff);
      end
      tag_shift    = SHIFT_W'(block_bits_ff) + SHIFT_W'(s_eff);
      addr_shifted = req_address >> block_bits_ff;
      for (int b = 0; b < IDX_W; b++) begin
         idx_mask[b] = (b < int'(s_eff));
      end
      set_idx = addr_shifted[IDX_W-1:0] & idx_mask;
      if (tag_shift >= SHIFT_W'(ADDR_W)) begin
         tag_val = '0;
      end else begin
         tag_val = req_address >> tag_shift;
      end
   end

   // unpack the set row and work out hit, fill or eviction
   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         // a ways count of zero behaves as one
         in_use[i]    = (i == 0) || (i < int'(ways_ff));
         way_tag[i]   = ram_rd_data[i*ENTRY_W +: ADDR_W];
         way_rank[i]  = ram_rd_data[i*ENTRY_W + ADDR_W +: RANK_W];
         way_valid[i] = ram_rd_data[i*ENTRY_W + ADDR_W + RANK_W];
         match[i]     = in_use[i] && way_valid[i] && (way_tag[i] == tag_ff);
         free[i]      = in_use[i] && !way_valid[i];
      end
      hit      = |match;
      has_free = |free;

      // lowest-numbered match and free way
      hit_way  = '0;
      free_way = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_way = RANK_W'(i);
         end
         if (free[i]) begin
            free_way = RANK_W'(i);
         end
      end

      // highest rank wins, lowest way on a tie
      victim = '0;
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (in_use[i] && (way_rank[i] > way_rank[victim])) begin
            victim = RANK_W'(i);
         end
      end

      if (hit) begin
         tgt_way  = hit_way;
         old_rank = {1'b0, way_rank[hit_way]};
      end else if (has_free) begin
         tgt_way  = free_way;
         old_rank = (RANK_W+1)'(MAX_WAYS);
      end else begin
         tgt_way  = victim;
         old_rank = {1'b0, way_rank[victim]};
      end

      // age the ways that were more recent than the touched one
      new_row = ram_rd_data;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (RANK_W'(i) == tgt_way) begin
            new_row[i*ENTRY_W + ADDR_W +: RANK_W] = '0;
            if (!hit) begin
               new_row[i*ENTRY_W +: ADDR_W]           = tag_ff;
               new_row[i*ENTRY_W + ADDR_W + RANK_W]   = 1'b1;
            end
         end else if (in_use[i] && way_valid[i] &&
                      ({1'b0, way_rank[i]} < old_rank) &&
                      (way_rank[i] < RANK_W'(MAX_WAYS - 1))) begin
            new_row[i*ENTRY_W + ADDR_W +: RANK_W] = way_rank[i] + 1'b1;
         end
      end
   end

   // sequencer: clearing pass, idle, row update
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = set_ff;
      ram_wr_data  = new_row;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = set_idx;
      rsp_valid_in = 1'b0;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            // all-zero row: every way invalid
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == IDX_W'(SET_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               ram_rd_en = 1'b1;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            ram_wr_en    = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (hit) begin
               if (hit_cnt_ff != COUNT_MAX) hit_cnt_in = hit_cnt_ff + 1'b1;
            end else begin
               if (miss_cnt_ff != COUNT_MAX) miss_cnt_in = miss_cnt_ff + 1'b1;
               if (!has_free && (evict_cnt_ff != COUNT_MAX)) begin
                  evict_cnt_in = evict_cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         evict_cnt_ff <= evict_cnt_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= '0;
         block_bits_ff <= '0;
         ways_ff       <= WAYS_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SET_BITS:    set_bits_ff   <= csr_data[SETB_W-1:0];
            REG_BLOCK_BITS:  block_bits_ff <= csr_data[BLKB_W-1:0];
            REG_WAYS_IN_USE: ways_ff       <= csr_data[WAYS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= set_idx;
         tag_ff <= tag_val;
      end
      if (state_ff == ST_LOOKUP) begin
         rsp_hit_ff     <= hit;
         rsp_evicted_ff <= !hit && !has_free;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_hit_total      = hit_cnt_ff;
   assign rsp_miss_total     = miss_cnt_ff;
   assign rsp_eviction_total = evict_cnt_ff;

endmodule
